// ===== rtl/sanc_pkg.sv =====
// sanc_pkg: shared types and constants for the set associative name cache
// no dependencies
`default_nettype none
package sanc_pkg;
   localparam int unsigned KEY_W  = 32;
   localparam int unsigned ID_W   = 64;
   localparam int unsigned STAT_W = 3;
   localparam int unsigned CNT_W  = 2;
   localparam logic [CNT_W-1:0] COUNT_MAX = 2'd3;

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0,
      OP_ENTER = 2'd1,
      OP_PURGE = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_MISS     = 3'd0,
      ST_NEGATIVE = 3'd1,
      ST_SAME_DIR = 3'd2,
      ST_FOUND    = 3'd3,
      ST_DONE     = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch request fields
      logic bucket_rd;   // issue bucket read at request index
      logic resolve;     // compare ways, write back
      logic purge_start; // reset purge address
      logic purge_rd;    // issue read at purge address
      logic purge_wr;    // evaluate returned bucket, clear matches
      logic purge_adv;   // advance purge address
      logic clear;       // zero valid bits and counts at purge address
      logic rsp_load;    // load response register
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      opcode_type op;
      logic       purge_last;
      logic       clear_last;
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/sanc_datapath.sv =====
// sanc_datapath: bucket memories, way compare, victim choice, purge sweep
// depends on sanc_pkg
`default_nettype none
module sanc_datapath
   import sanc_pkg::*;
#(
   parameter int unsigned SETS = 256,
   parameter int unsigned WAYS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_type           ctl,
   output sts_type                sts,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [ID_W-1:0]   req_dir,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [ID_W-1:0]   req_name,
   input  wire logic [ID_W-1:0]   req_node,
   input  wire logic              req_parent,
   input  wire logic [ID_W-1:0]   root_dir,
   output logic [STAT_W-1:0]      out_status,
   output logic [ID_W-1:0]        out_node
);
   localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned WAY_W = $clog2(WAYS);

   // one memory per way, all ways of a bucket read together
   logic [KEY_W-1:0] key_mem  [WAYS][SETS];
   logic [ID_W-1:0]  dir_mem  [WAYS][SETS];
   logic [ID_W-1:0]  name_mem [WAYS][SETS];
   logic [ID_W-1:0]  node_mem [WAYS][SETS];

   // per bucket valid bits and packed use counts, cleared by a pass after reset
   logic [WAYS-1:0]       valid_mem [SETS];
   logic [WAYS*CNT_W-1:0] cnt_mem   [SETS];

   logic [1:0]       op_ff;
   logic [ID_W-1:0]  dir_ff, name_ff, node_ff;
   logic [KEY_W-1:0] key_ff;
   logic             parent_ff;
   logic [SET_W-1:0] set_ff, purge_ff;
   logic [WAY_W-1:0] rr_ff;

   logic [KEY_W-1:0]      rd_key  [WAYS];
   logic [ID_W-1:0]       rd_dir  [WAYS];
   logic [ID_W-1:0]       rd_name [WAYS];
   logic [ID_W-1:0]       rd_node [WAYS];
   logic [WAYS-1:0]       rd_valid;
   logic [WAYS*CNT_W-1:0] rd_cnt;
   logic [SET_W-1:0]      rd_addr;

   logic [STAT_W-1:0] status_ff;
   logic [ID_W-1:0]   node_out_ff;

   // bucket index: key modulo SETS; SETS a power of two in practice uses low bits
   logic [SET_W-1:0] set_in;
   always_comb begin
      set_in = SET_W'(req_key % KEY_W'(SETS));
   end

   assign rd_addr = ctl.purge_rd ? purge_ff : set_ff;

   // hit and victim search on the registered bucket
   logic             hit;
   logic [WAY_W-1:0] hit_way, pick_way;
   logic [CNT_W-1:0] best;
   logic [CNT_W-1:0] way_cnt;
   logic             root_parent;
   always_comb begin
      hit = 1'b0;
      hit_way = '0;
      best = COUNT_MAX;
      pick_way = '0;
      way_cnt = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rd_valid[w] && rd_key[w] == key_ff && rd_dir[w] == dir_ff
             && rd_name[w] == name_ff) begin
            hit = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         way_cnt = rd_valid[w] ? rd_cnt[w*CNT_W +: CNT_W] : '0;
         if (way_cnt < best) begin
            best = way_cnt;
            pick_way = WAY_W'(w);
         end
      end
      if (best == COUNT_MAX) pick_way = rr_ff;
      root_parent = parent_ff && (dir_ff == root_dir);
   end

   logic lookup;
   assign lookup = (op_ff == OP_ENTER) || (op_ff == OP_CHECK && !root_parent);

   // purge evaluates the bucket read the cycle before
   logic [SET_W-1:0] purge_rd_ff;

   // one valid/count write per cycle: clearing pass, purge clear or lookup write-back
   logic                  meta_we;
   logic [SET_W-1:0]      meta_addr;
   logic [WAYS-1:0]       valid_wr;
   logic [WAYS*CNT_W-1:0] cnt_wr;
   always_comb begin
      meta_we = 1'b0;
      meta_addr = set_ff;
      valid_wr = rd_valid;
      cnt_wr = rd_cnt;
      if (ctl.clear) begin
         meta_we = 1'b1;
         meta_addr = purge_ff;
         valid_wr = '0;
         cnt_wr = '0;
      end else if (ctl.purge_wr) begin
         meta_we = 1'b1;
         meta_addr = purge_rd_ff;
         for (int w = 0; w < WAYS; w++) begin
            if (rd_valid[w] && rd_dir[w] == dir_ff && rd_node[w] == node_ff) begin
               valid_wr[w] = 1'b0;
               cnt_wr[w*CNT_W +: CNT_W] = '0;
            end
         end
      end else if (ctl.resolve && lookup) begin
         meta_we = 1'b1;
         for (int w = 0; w < WAYS; w++) begin
            if (hit && hit_way == WAY_W'(w)) begin
               if (rd_cnt[w*CNT_W +: CNT_W] != COUNT_MAX)
                  cnt_wr[w*CNT_W +: CNT_W] = rd_cnt[w*CNT_W +: CNT_W] + 1'b1;
            end else if (!hit && op_ff == OP_ENTER && pick_way == WAY_W'(w)) begin
               valid_wr[w] = 1'b1;
               cnt_wr[w*CNT_W +: CNT_W] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         op_ff <= req_opcode;
         dir_ff <= req_dir;
         key_ff <= req_key;
         name_ff <= req_name;
         node_ff <= req_node;
         parent_ff <= req_parent;
         set_ff <= set_in;
      end
      if (ctl.bucket_rd || ctl.purge_rd) begin
         for (int w = 0; w < WAYS; w++) begin
            rd_key[w]  <= key_mem[w][rd_addr];
            rd_dir[w]  <= dir_mem[w][rd_addr];
            rd_name[w] <= name_mem[w][rd_addr];
            rd_node[w] <= node_mem[w][rd_addr];
         end
         rd_valid <= valid_mem[rd_addr];
         rd_cnt <= cnt_mem[rd_addr];
      end
      if (meta_we) begin
         valid_mem[meta_addr] <= valid_wr;
         cnt_mem[meta_addr] <= cnt_wr;
      end
      if (ctl.resolve && op_ff == OP_ENTER) begin
         for (int w = 0; w < WAYS; w++) begin
            if (hit && hit_way == WAY_W'(w)) begin
               node_mem[w][set_ff] <= node_ff;
            end else if (!hit && pick_way == WAY_W'(w)) begin
               key_mem[w][set_ff]  <= key_ff;
               dir_mem[w][set_ff]  <= dir_ff;
               name_mem[w][set_ff] <= name_ff;
               node_mem[w][set_ff] <= node_ff;
            end
         end
      end
      if (ctl.rsp_load) begin
         status_ff <= ST_MISS;
         node_out_ff <= '0;
         if (op_ff == OP_ENTER || op_ff == OP_PURGE) begin
            status_ff <= ST_DONE;
         end else if (op_ff == OP_CHECK && !root_parent && hit) begin
            if (rd_node[hit_way] == '0) status_ff <= ST_NEGATIVE;
            else if (rd_node[hit_way] == dir_ff) status_ff <= ST_SAME_DIR;
            else begin
               status_ff <= ST_FOUND;
               node_out_ff <= rd_node[hit_way];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_ff <= '0;
         purge_ff <= '0;
      end else begin
         if (ctl.purge_start) purge_ff <= '0;
         if (ctl.purge_rd) purge_rd_ff <= purge_ff;
         if (ctl.purge_adv) purge_ff <= purge_ff + 1'b1;
         if (ctl.resolve && lookup && !hit && best == COUNT_MAX)
            rr_ff <= (32'(rr_ff) + 1 == WAYS) ? '0 : rr_ff + 1'b1;
      end
   end

   assign sts.op = opcode_type'(op_ff);
   assign sts.purge_last = (32'(purge_rd_ff) == SETS - 1);
   assign sts.clear_last = (32'(purge_ff) == SETS - 1);
   assign out_status = status_ff;
   assign out_node = node_out_ff;
endmodule
`default_nettype wire

// ===== rtl/sanc_ctrl.sv =====
// sanc_ctrl: sequencer for lookup, enter and purge transactions
// depends on sanc_pkg
`default_nettype none
module sanc_ctrl
   import sanc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_fire,
   input  wire logic    rsp_fire,
   input  wire sts_type sts,
   output ctl_type      ctl,
   output logic         busy,
   output logic         rsp_valid
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_RESOLVE, S_PURGE_RD, S_PURGE_WR, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl = '0;
      if (rsp_fire) rsp_valid_in = 1'b0;
      unique case (state_ff)
         // walk every bucket once after reset
         S_CLEAR: begin
            ctl.clear = 1'b1;
            ctl.purge_adv = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: if (req_fire) begin
            ctl.capture = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            if (sts.op == OP_PURGE) begin
               ctl.purge_start = 1'b1;
               state_in = S_PURGE_RD;
            end else begin
               ctl.bucket_rd = 1'b1;
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            ctl.resolve = 1'b1;
            state_in = S_RESP;
         end
         S_PURGE_RD: begin
            ctl.purge_rd = 1'b1;
            ctl.purge_adv = 1'b1;
            state_in = S_PURGE_WR;
         end
         S_PURGE_WR: begin
            ctl.purge_wr = 1'b1;
            state_in = sts.purge_last ? S_RESP : S_PURGE_RD;
         end
         S_RESP: if (!rsp_valid_ff || rsp_fire) begin
            ctl.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ===== rtl/set_assoc_name_cache_lfu.sv =====
// set_assoc_name_cache_lfu: top level of the set associative name cache
// depends on sanc_pkg, sanc_ctrl, sanc_datapath
//
//  channel   direction  handshake            payload
//  req_      in         req_tvalid/tready    tdata: opcode, dir_id, key_hash, name_tag,
//                                            node_id; tuser: is_parent_name
//  rsp_      out        rsp_tvalid/tready    tdata: status, found_node
//  csr_      in         csr_valid/ready      csr_data: root_dir_id
//
// check and enter step through capture, bucket read, compare and write-back,
// response load. purge does one bucket read and one clear per set. reset
// clears the round-robin pointer at once, then a pass over every bucket zeroes
// valid bits and use counts while req_tready stays low.
// a new request is taken while the previous response waits.
`default_nettype none
module set_assoc_name_cache_lfu
   import sanc_pkg::*;
#(
   parameter int unsigned SETS = 256,
   parameter int unsigned WAYS = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [231:0] req_tdata,  // opcode, dir_id, key_hash, name_tag, node_id
   input  wire logic         req_tuser,  // is_parent_name
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [71:0]       rsp_tdata,  // status, found_node, zero fill
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [63:0]  csr_data
);
   ctl_type ctl;
   sts_type sts;
   logic busy, req_fire, rsp_fire;
   logic [ID_W-1:0]   root_ff;
   logic [STAT_W-1:0] st;
   logic [ID_W-1:0]   nd;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) root_ff <= '0;
      else if (csr_valid) root_ff <= csr_data;
   end

   sanc_ctrl u_ctrl (
      .clock, .reset, .req_fire, .rsp_fire, .sts, .ctl, .busy,
      .rsp_valid(rsp_tvalid)
   );

   sanc_datapath #(.SETS(SETS), .WAYS(WAYS)) u_dp (
      .clock, .reset, .ctl, .sts,
      .req_opcode(req_tdata[1:0]),
      .req_dir(req_tdata[65:2]),
      .req_key(req_tdata[97:66]),
      .req_name(req_tdata[161:98]),
      .req_node(req_tdata[225:162]),
      .req_parent(req_tuser),
      .root_dir(root_ff),
      .out_status(st),
      .out_node(nd)
   );

   assign rsp_tdata = {5'd0, nd, st};

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.capture, ctl.bucket_rd, ctl.resolve, ctl.purge_rd, ctl.purge_wr,
                ctl.clear, ctl.rsp_load}))
      else $error("more than one datapath command");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy)
      else $error("request accepted without going busy");
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |=> rsp_tvalid)
      else $error("response load did not raise valid");
endmodule
`default_nettype wire
